// File: rtl/disk_seek_schedule_total_unit_defines.svh
// Assertion macros for the disk seek schedule total unit.
`ifndef DISK_SEEK_SCHEDULE_TOTAL_UNIT_DEFINES_SVH
`define DISK_SEEK_SCHEDULE_TOTAL_UNIT_DEFINES_SVH

// Overlapping implication, checked outside reset.
`define DSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dss_pkg.sv
// Types and constants shared by the disk seek schedule total unit.
package dss_pkg;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CLR  = 6'b000010,
    ST_PASS = 6'b000100,
    ST_RND  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [2:0] MODE_FCFS  = 3'd0;
  localparam logic [2:0] MODE_SSTF  = 3'd1;
  localparam logic [2:0] MODE_SCAN  = 3'd2;
  localparam logic [2:0] MODE_CSCAN = 3'd3;
  localparam logic [2:0] MODE_LOOK  = 3'd4;
  localparam logic [2:0] MODE_CLOOK = 3'd5;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam int          ACC_W       = 24;
  localparam logic [12:0] CCOUNT_RST  = 13'd200;
  localparam logic [19:0] MOVE_MAX    = 20'hFFFFF;

endpackage

// File: rtl/disk_seek_schedule_total_unit.sv
// Top level: disk head schedule total movement, loader plus iterative pass engine.
//
// Usage:
//   Requests arrive on in_valid/in_stall with in_cylinder and in_last, one per
//   cycle while the unit is loading. A request with in_last closes the batch;
//   the unit then stalls its input and walks the stored requests with one
//   shared compare/add datapath, reading one entry per cycle from the store.
//   One result (out_total_movement, out_overflow) leaves on out_valid/out_stall.
// Sequence after the last request (n = requests held):
//   FCFS: one pass for the running sum, then the result state.
//   SCAN, C-SCAN, LOOK, C-LOOK: one pass for min/max, a finish state,
//   then the result state.
//   SSTF: a clear pass over the n served marks, then n rounds, each a single
//   scan over the served marks and a round update, then the result state.
// Throughput: one request per cycle while loading; no new request is taken
//   while a batch is being computed.
// Stall: a result held by out_stall keeps its register; the unit still loads
//   the next batch, and waits in its final state if that batch finishes first.
// Reset: clears request count, drop flag, output valid and registers to their
//   defaults (policy FCFS, start 0, 200 cylinders). The store needs no clearing.
// Requests past MAX_REQUESTS are dropped and reported as overflow.
`include "disk_seek_schedule_total_unit_defines.svh"

module disk_seek_schedule_total_unit #(
  parameter int MAX_REQUESTS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_cylinder,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_total_movement,
  output logic        out_overflow
);

  localparam int AW = $clog2(MAX_REQUESTS);
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int AC = dss_pkg::ACC_W;

  // configuration registers
  logic [2:0]  policy_r;
  logic [11:0] start_r;
  logic [12:0] ccount_r;

  // control
  dss_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          ovf_r, ovf_nxt;
  logic          oval_r, oval_nxt;
  logic          iss_act_r, iss_act_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [AW-1:0] iss_idx_r, iss_idx_nxt;
  logic [CW-1:0] rnd_r, rnd_nxt;

  // datapath
  logic [AW-1:0] p_idx_r, p_idx_nxt;
  logic [AC-1:0] acc_r, acc_nxt;
  logic [11:0]   head_r, head_nxt;
  logic          found_r, found_nxt;
  logic [11:0]   bestd_r, bestd_nxt;
  logic [11:0]   bestv_r, bestv_nxt;
  logic [AW-1:0] besti_r, besti_nxt;
  logic [11:0]   mn_r, mn_nxt;
  logic [11:0]   mx_r, mx_nxt;
  logic [11:0]   ml_r, ml_nxt;
  logic [19:0]   otot_r, otot_nxt;
  logic          oovf_r, oovf_nxt;

  // memories
  logic [11:0] req_mem [MAX_REQUESTS];
  logic        mark_mem [MAX_REQUESTS];
  logic [11:0] rd_val_r;
  logic        rd_mark_r;
  logic        rd_en, st_we, mk_we, mk_wd;
  logic [AW-1:0] mk_wa;

  logic in_acc, out_free, has_room, is_sstf, is_fcfs, iss_end;
  logic [11:0] d_cur;
  logic [12:0] top, hd3;
  logic [13:0] fin_sum;

  assign in_stall = (state_r != dss_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !oval_r || !out_stall;
  assign has_room = (cnt_r < CW'(MAX_REQUESTS));
  assign is_sstf  = (policy_r == dss_pkg::MODE_SSTF);
  assign is_fcfs  = (policy_r == dss_pkg::MODE_FCFS) || (policy_r > dss_pkg::MODE_CLOOK);
  assign iss_end  = (CW'(iss_idx_r) == cnt_r - CW'(1));

  assign out_valid          = oval_r;
  assign out_total_movement = otot_r;
  assign out_overflow       = oovf_r;

  // distance of the entry in flight from the head
  assign d_cur = (rd_val_r > head_r) ? rd_val_r - head_r : head_r - rd_val_r;

  // sweep policies reduce to min, max and largest-below-start; see finish
  assign top = (ccount_r != 13'd0) ? ccount_r - 13'd1 : 13'd0;
  assign hd3 = (mx_r >= start_r) ? {1'b0, mx_r} : {1'b0, start_r};

  always_comb begin
    fin_sum = '0;
    case (policy_r)
      dss_pkg::MODE_SCAN: begin
        fin_sum = {2'b0, start_r} + ((mx_r > start_r) ? {2'b0, mx_r} : 14'd0);
      end
      dss_pkg::MODE_LOOK: begin
        if (mn_r <= start_r && mx_r > start_r) begin
          fin_sum = {2'b0, start_r - mn_r} + {2'b0, mx_r - mn_r};
        end else if (mn_r <= start_r) begin
          fin_sum = {2'b0, start_r - mn_r};
        end else begin
          fin_sum = {2'b0, mx_r - start_r};
        end
      end
      dss_pkg::MODE_CSCAN: begin
        fin_sum = ((mx_r >= start_r) ? {2'b0, mx_r - start_r} : 14'd0)
                + {1'b0, (top > hd3) ? top - hd3 : hd3 - top}
                + ((mn_r < start_r) ? {2'b0, ml_r} : 14'd0);
      end
      dss_pkg::MODE_CLOOK: begin
        fin_sum = ((mx_r >= start_r) ? {2'b0, mx_r - start_r} : 14'd0)
                + ((mn_r < start_r) ? {2'b0, ml_r - mn_r} : 14'd0);
      end
      default: fin_sum = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    drop_nxt    = drop_r;
    ovf_nxt     = ovf_r;
    oval_nxt    = oval_r && out_stall;
    iss_act_nxt = iss_act_r;
    p_vld_nxt   = 1'b0;
    iss_idx_nxt = iss_idx_r;
    rnd_nxt     = rnd_r;
    p_idx_nxt   = iss_idx_r;
    acc_nxt     = acc_r;
    head_nxt    = head_r;
    found_nxt   = found_r;
    bestd_nxt   = bestd_r;
    bestv_nxt   = bestv_r;
    besti_nxt   = besti_r;
    mn_nxt      = mn_r;
    mx_nxt      = mx_r;
    ml_nxt      = ml_r;
    otot_nxt    = otot_r;
    oovf_nxt    = oovf_r;
    rd_en       = 1'b0;
    st_we       = 1'b0;
    mk_we       = 1'b0;
    mk_wd       = 1'b0;
    mk_wa       = iss_idx_r;

    case (state_r)
      dss_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (has_room) begin
            st_we   = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            ovf_nxt     = drop_r || !has_room;
            iss_idx_nxt = '0;
            rnd_nxt     = '0;
            acc_nxt     = '0;
            head_nxt    = start_r;
            found_nxt   = 1'b0;
            mn_nxt      = 12'hFFF;
            mx_nxt      = '0;
            ml_nxt      = '0;
            if (is_sstf) begin
              state_nxt = dss_pkg::ST_CLR;
            end else begin
              state_nxt   = dss_pkg::ST_PASS;
              iss_act_nxt = 1'b1;
            end
          end
        end
      end
      dss_pkg::ST_CLR: begin
        mk_we = 1'b1;
        if (iss_end) begin
          iss_idx_nxt = '0;
          iss_act_nxt = 1'b1;
          state_nxt   = dss_pkg::ST_PASS;
        end else begin
          iss_idx_nxt = iss_idx_r + AW'(1);
        end
      end
      dss_pkg::ST_PASS: begin
        if (iss_act_r) begin
          rd_en     = 1'b1;
          p_vld_nxt = 1'b1;
          if (iss_end) begin
            iss_act_nxt = 1'b0;
          end else begin
            iss_idx_nxt = iss_idx_r + AW'(1);
          end
        end
        if (p_vld_r) begin
          if (is_sstf) begin
            if (!rd_mark_r && (!found_r || d_cur < bestd_r)) begin
              found_nxt = 1'b1;
              bestd_nxt = d_cur;
              bestv_nxt = rd_val_r;
              besti_nxt = p_idx_r;
            end
          end else if (is_fcfs) begin
            acc_nxt  = acc_r + AC'(d_cur);
            head_nxt = rd_val_r;
          end else begin
            if (rd_val_r < mn_r) mn_nxt = rd_val_r;
            if (rd_val_r > mx_r) mx_nxt = rd_val_r;
            if (rd_val_r < start_r && rd_val_r > ml_r) ml_nxt = rd_val_r;
          end
        end
        if (!iss_act_r && !p_vld_r) begin
          if (is_sstf) begin
            state_nxt = dss_pkg::ST_RND;
          end else if (is_fcfs) begin
            state_nxt = dss_pkg::ST_DONE;
          end else begin
            state_nxt = dss_pkg::ST_FIN;
          end
        end
      end
      dss_pkg::ST_RND: begin
        mk_we     = 1'b1;
        mk_wd     = 1'b1;
        mk_wa     = besti_r;
        acc_nxt   = acc_r + AC'(bestd_r);
        head_nxt  = bestv_r;
        found_nxt = 1'b0;
        rnd_nxt   = rnd_r + CW'(1);
        if (rnd_r + CW'(1) == cnt_r) begin
          state_nxt = dss_pkg::ST_DONE;
        end else begin
          iss_idx_nxt = '0;
          iss_act_nxt = 1'b1;
          state_nxt   = dss_pkg::ST_PASS;
        end
      end
      dss_pkg::ST_FIN: begin
        acc_nxt   = AC'(fin_sum);
        state_nxt = dss_pkg::ST_DONE;
      end
      dss_pkg::ST_DONE: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          otot_nxt  = (acc_r > AC'(dss_pkg::MOVE_MAX)) ? dss_pkg::MOVE_MAX : acc_r[19:0];
          oovf_nxt  = ovf_r;
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = dss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dss_pkg::ST_IDLE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      ovf_r     <= 1'b0;
      oval_r    <= 1'b0;
      iss_act_r <= 1'b0;
      p_vld_r   <= 1'b0;
      policy_r  <= dss_pkg::MODE_FCFS;
      start_r   <= '0;
      ccount_r  <= dss_pkg::CCOUNT_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      ovf_r     <= ovf_nxt;
      oval_r    <= oval_nxt;
      iss_act_r <= iss_act_nxt;
      p_vld_r   <= p_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dss_pkg::REG_POLICY: policy_r <= cfg_wdata[2:0];
          dss_pkg::REG_START:  start_r  <= cfg_wdata[11:0];
          dss_pkg::REG_COUNT:  ccount_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    iss_idx_r <= iss_idx_nxt;
    rnd_r     <= rnd_nxt;
    p_idx_r   <= p_idx_nxt;
    acc_r     <= acc_nxt;
    head_r    <= head_nxt;
    found_r   <= found_nxt;
    bestd_r   <= bestd_nxt;
    bestv_r   <= bestv_nxt;
    besti_r   <= besti_nxt;
    mn_r      <= mn_nxt;
    mx_r      <= mx_nxt;
    ml_r      <= ml_nxt;
    otot_r    <= otot_nxt;
    oovf_r    <= oovf_nxt;
  end

  // request store and served marks
  always_ff @(posedge clk) begin
    if (st_we) req_mem[cnt_r[AW-1:0]] <= in_cylinder;
    if (rd_en) rd_val_r <= req_mem[iss_idx_r];
  end

  always_ff @(posedge clk) begin
    if (mk_we) mark_mem[mk_wa] <= mk_wd;
    if (rd_en) rd_mark_r <= mark_mem[iss_idx_r];
  end

  `DSS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_REQUESTS), "count past capacity")
  `DSS_ASSERT_NEXT(a_last_starts, in_acc && in_last, state_r != dss_pkg::ST_IDLE, "stuck idle")
  `DSS_ASSERT_NOW(a_rise_from_done, $rose(oval_r), $past(state_r) == dss_pkg::ST_DONE, "bad rise")

endmodule
